// ----- rtl/core/refr_pkg.sv -----
// ----------------------------------------------------------------------------
// refr_pkg: shared types and constants for the refraction pipeline
// Item formats, outcome codes and the stage map of the back pipeline.
// ----------------------------------------------------------------------------
package refr_pkg;

  // Component width of every vector field and index (Q2.14).
  localparam int CW = 16;

  // Outcome codes.
  localparam logic [1:0] OUT_OK      = 2'd0;
  localparam logic [1:0] OUT_TIR     = 2'd1;
  localparam logic [1:0] OUT_BAD_DOT = 2'd2;
  localparam logic [1:0] OUT_ZERO    = 2'd3;

  // Largest index ratio, just under 64.0 in Q.14.
  localparam logic [19:0] ETA_MAX = 20'hFFFFF;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Back pipeline stage map.
  localparam int ST_PRE   = 0;
  localparam int DIV0     = 1;   // index ratio divider, one quotient bit per stage
  localparam int DIV_N    = 20;
  localparam int ST_ETA   = DIV0 + DIV_N;
  localparam int ST_KPROD = ST_ETA + 1;
  localparam int ST_K     = ST_KPROD + 1;
  localparam int SQK0     = ST_K + 1;   // square root of k, one root bit per stage
  localparam int SQK_N    = 15;
  localparam int ST_AB    = SQK0 + SQK_N;
  localparam int ST_TP    = ST_AB + 1;
  localparam int ST_T     = ST_TP + 1;
  localparam int ST_MAG   = ST_T + 1;
  localparam int ST_MAX   = ST_MAG + 1;
  localparam int ST_LZ    = ST_MAX + 1;
  localparam int ST_NORM  = ST_LZ + 1;
  localparam int ST_SQ    = ST_NORM + 1;
  localparam int ST_SUM   = ST_SQ + 1;
  localparam int SQS0     = ST_SUM + 1;  // square root of the length sum
  localparam int SQS_N    = 31;
  localparam int QD0      = SQS0 + SQS_N; // normalizing dividers
  localparam int QD_N     = 15;
  localparam int N_ST     = QD0 + QD_N;

  typedef logic signed [CW-1:0] cmp_t;

  // Item as classified by the front.
  typedef struct packed {
    cmp_t [2:0]         nrm;
    cmp_t [2:0]         eye;
    logic [CW-1:0]      ni;
    logic [CW-1:0]      nt;
    logic signed [32:0] dot;
    logic               zro;
    logic               sat;
  } fr_t;

  // Working set carried down the back pipeline.
  typedef struct packed {
    logic               fail;
    logic [1:0]         code;
    logic               zro;
    logic               sat;
    cmp_t [2:0]         nrm;
    cmp_t [2:0]         eye;
    logic [CW-1:0]      nt;
    logic [5:0]         nlo;
    logic [15:0]        drem;
    logic [19:0]        eta;
    logic signed [18:0] en;
    logic signed [37:0] s;
    logic [39:0]        eta2f;
    logic [54:0]        kp;
    logic [29:0]        kv;
    logic [16:0]        krem;
    logic [14:0]        kroot;
    logic [2:0][35:0]   a;
    logic [2:0][31:0]   b;
    logic [2:0][56:0]   p;
    logic [2:0][56:0]   t;
    logic [2:0]         neg;
    logic [2:0][56:0]   mag;
    logic [56:0]        mx;
    logic [5:0]         pos;
    logic [2:0][29:0]   nm;
    logic [2:0][59:0]   sq;
    logic [61:0]        sv;
    logic [32:0]        srem;
    logic [30:0]        sroot;
    logic [2:0][30:0]   qrem;
    logic [2:0]         qlo;
    logic [2:0][14:0]   quo;
  } bk_t;

endpackage

// ----- rtl/core/refr_front.sv -----
// ----------------------------------------------------------------------------
// refr_front: input stage
// Accepts items, forms the dot product and flags zero and saturating indices.
// ----------------------------------------------------------------------------
module refr_front
  import refr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // normal_x, normal_y, normal_z, eye_x, eye_y, eye_z, index_incident,
  // index_transmit, 16 bits each from the lowest bit up
  input  logic [127:0] in_tdata,
  output logic         push,
  output fr_t          push_data,
  input  logic         q_full
);

  logic f_vld_r, f_vld_nxt;
  fr_t  f_r, f_nxt;
  logic acc;

  // A held item leaves when the queue has room.
  assign push      = f_vld_r && !q_full;
  assign in_tready = !f_vld_r || !q_full;
  assign acc       = in_tvalid && in_tready;
  assign push_data = f_r;

  // Unpack and classify the incoming item.
  always_comb begin
    f_nxt.nrm[0] = $signed(in_tdata[15:0]);
    f_nxt.nrm[1] = $signed(in_tdata[31:16]);
    f_nxt.nrm[2] = $signed(in_tdata[47:32]);
    f_nxt.eye[0] = $signed(in_tdata[63:48]);
    f_nxt.eye[1] = $signed(in_tdata[79:64]);
    f_nxt.eye[2] = $signed(in_tdata[95:80]);
    f_nxt.ni     = in_tdata[111:96];
    f_nxt.nt     = in_tdata[127:112];
    f_nxt.dot    = $signed(f_nxt.nrm[0]) * $signed(f_nxt.eye[0])
                 + $signed(f_nxt.nrm[1]) * $signed(f_nxt.eye[1])
                 + $signed(f_nxt.nrm[2]) * $signed(f_nxt.eye[2]);
    f_nxt.zro    = (f_nxt.ni == '0) || (f_nxt.nt == '0);
    // The ratio reaches 64.0 exactly when ni >= 64 * nt.
    f_nxt.sat    = ({6'd0, f_nxt.ni} >= {f_nxt.nt, 6'd0});
  end

  always_comb begin
    f_vld_nxt = f_vld_r;
    if (acc) begin
      f_vld_nxt = 1'b1;
    end else if (push) begin
      f_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f_r <= f_nxt;
    end
  end

endmodule

// ----- rtl/core/refr_queue.sv -----
// ----------------------------------------------------------------------------
// refr_queue: short item queue
// Decouples the front from the back so each side can stall on its own.
// ----------------------------------------------------------------------------
module refr_queue
  import refr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  fr_t  wr_data,
  output logic full,
  input  logic rd_en,
  output fr_t  rd_data,
  output logic nempty
);

  fr_t            mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign nempty  = (cnt_r != '0);
  assign rd_data = mem_r[rp_r];

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/refr_back.sv -----
// ----------------------------------------------------------------------------
// refr_back: refraction pipeline
// Index ratio divider, square roots, refracted vector and normalization,
// one stage per step, advancing as a whole when the output can move.
// ----------------------------------------------------------------------------
module refr_back
  import refr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nempty,
  input  fr_t         q_data,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  // dir_x, dir_y, dir_z, 16 bits each from the lowest bit up
  output logic [47:0] out_tdata,
  // outcome
  output logic [1:0]  out_tuser
);

  // Set up the first stage: dot product scaling and divider start.
  function automatic bk_t prep(input fr_t f);
    bk_t r;
    r      = '0;
    r.code = OUT_OK;
    r.zro  = f.zro;
    r.sat  = f.sat;
    r.nrm  = f.nrm;
    r.eye  = f.eye;
    r.nt   = f.nt;
    r.nlo  = f.ni[5:0];
    r.drem = {6'd0, f.ni[15:6]};
    r.en   = f.dot[32:14];
    r.s    = (38'sd1 <<< 28) - r.en * r.en;
    return r;
  endfunction

  // One pipeline step; the stage number selects the work.
  function automatic bk_t step(input int unsigned i, input bk_t c);
    bk_t                r;
    logic [16:0]        dr2;
    logic signed [56:0] k;
    logic [18:0]        ktmp;
    logic [16:0]        ktri;
    logic [34:0]        stmp;
    logic [32:0]        stri;
    logic [31:0]        qr2;
    logic signed [34:0] ne;
    logic signed [35:0] av;
    logic signed [31:0] bv;
    logic signed [56:0] pv;
    logic [56:0]        mx;
    int                 j;
    int                 b;
    r = c;
    if (i >= DIV0 && i < DIV0 + DIV_N) begin
      // Restoring divide of ni * 2^14 by nt, one quotient bit.
      dr2 = {c.drem, c.nlo[5]};
      if (dr2 >= {1'b0, c.nt}) begin
        dr2   = dr2 - {1'b0, c.nt};
        r.eta = {c.eta[18:0], 1'b1};
      end else begin
        r.eta = {c.eta[18:0], 1'b0};
      end
      r.drem = dr2[15:0];
      r.nlo  = {c.nlo[4:0], 1'b0};
    end else if (i == ST_ETA) begin
      r.eta   = c.sat ? ETA_MAX : c.eta;
      r.eta2f = r.eta * r.eta;
      if (c.zro) begin
        r.fail = 1'b1;
        r.code = OUT_ZERO;
      end else if (c.s < 0) begin
        r.fail = 1'b1;
        r.code = OUT_BAD_DOT;
      end
    end else if (i == ST_KPROD) begin
      r.kp = c.eta2f[39:14] * c.s[28:0];
    end else if (i == ST_K) begin
      k = $signed(57'd1 << 42) - $signed({2'b00, c.kp});
      if (!c.fail && k < 0) begin
        r.fail = 1'b1;
        r.code = OUT_TIR;
      end
      r.kv    = k[43:14];
      r.krem  = '0;
      r.kroot = '0;
    end else if (i >= SQK0 && i < SQK0 + SQK_N) begin
      // Digit-by-digit square root of k, one root bit.
      ktmp = {c.krem, c.kv[29:28]};
      ktri = {c.kroot, 2'b01};
      if (ktmp >= {2'b00, ktri}) begin
        ktmp    = ktmp - {2'b00, ktri};
        r.kroot = {c.kroot[13:0], 1'b1};
      end else begin
        r.kroot = {c.kroot[13:0], 1'b0};
      end
      r.krem = ktmp[16:0];
      r.kv   = {c.kv[27:0], 2'b00};
    end else if (i == ST_AB) begin
      for (j = 0; j < 3; j++) begin
        ne = $signed(c.nrm[j]) * c.en;
        av = ne - (36'($signed(c.eye[j])) <<< 14);
        bv = $signed(c.nrm[j]) * $signed({1'b0, c.kroot});
        r.a[j] = av;
        r.b[j] = bv;
      end
    end else if (i == ST_TP) begin
      for (j = 0; j < 3; j++) begin
        pv = $signed(c.a[j]) * $signed({1'b0, c.eta});
        r.p[j] = pv;
      end
    end else if (i == ST_T) begin
      for (j = 0; j < 3; j++) begin
        pv = $signed(c.p[j]) - ($signed(c.b[j]) <<< 14);
        r.t[j] = pv;
      end
    end else if (i == ST_MAG) begin
      for (j = 0; j < 3; j++) begin
        r.neg[j] = c.t[j][56];
        r.mag[j] = c.t[j][56] ? (57'd0 - c.t[j]) : c.t[j];
      end
    end else if (i == ST_MAX) begin
      mx = c.mag[0];
      if (c.mag[1] > mx) begin
        mx = c.mag[1];
      end
      if (c.mag[2] > mx) begin
        mx = c.mag[2];
      end
      r.mx = mx;
      if (!c.fail && mx == '0) begin
        r.fail = 1'b1;
        r.code = OUT_ZERO;
      end
    end else if (i == ST_LZ) begin
      // Position of the leading one of the largest magnitude.
      r.pos = '0;
      for (b = 0; b < 57; b++) begin
        if (c.mx[b]) begin
          r.pos = 6'(b);
        end
      end
    end else if (i == ST_NORM) begin
      // Bring the largest magnitude into [2^29, 2^30).
      for (j = 0; j < 3; j++) begin
        if (c.pos >= 6'd29) begin
          r.nm[j] = 30'(c.mag[j] >> (c.pos - 6'd29));
        end else begin
          r.nm[j] = 30'(c.mag[j] << (6'd29 - c.pos));
        end
      end
    end else if (i == ST_SQ) begin
      for (j = 0; j < 3; j++) begin
        r.sq[j] = c.nm[j] * c.nm[j];
      end
    end else if (i == ST_SUM) begin
      r.sv    = {2'b00, c.sq[0]} + {2'b00, c.sq[1]} + {2'b00, c.sq[2]};
      r.srem  = '0;
      r.sroot = '0;
      for (j = 0; j < 3; j++) begin
        r.qrem[j] = {2'b00, c.nm[j][29:1]};
        r.qlo[j]  = c.nm[j][0];
        r.quo[j]  = '0;
      end
    end else if (i >= SQS0 && i < SQS0 + SQS_N) begin
      // Square root of the sum of squares, one root bit.
      stmp = {c.srem, c.sv[61:60]};
      stri = {c.sroot, 2'b01};
      if (stmp >= {2'b00, stri}) begin
        stmp    = stmp - {2'b00, stri};
        r.sroot = {c.sroot[29:0], 1'b1};
      end else begin
        r.sroot = {c.sroot[29:0], 1'b0};
      end
      r.srem = stmp[32:0];
      r.sv   = {c.sv[59:0], 2'b00};
    end else if (i >= QD0 && i < QD0 + QD_N) begin
      // Magnitude * 2^14 / length, one quotient bit per lane.
      for (j = 0; j < 3; j++) begin
        qr2 = {c.qrem[j], c.qlo[j]};
        if (qr2 >= {1'b0, c.sroot}) begin
          qr2      = qr2 - {1'b0, c.sroot};
          r.quo[j] = {c.quo[j][13:0], 1'b1};
        end else begin
          r.quo[j] = {c.quo[j][13:0], 1'b0};
        end
        r.qrem[j] = qr2[30:0];
        r.qlo[j]  = 1'b0;
      end
    end
    return r;
  endfunction

  bk_t               st_r   [N_ST];
  bk_t               st_nxt [N_ST];
  logic [N_ST-1:0]   vld_r, vld_nxt;
  logic              adv;
  logic              out_vld_r, out_vld_nxt;
  logic [47:0]       out_data_r, out_data_nxt;
  logic [1:0]        out_user_r, out_user_nxt;
  bk_t               lst;

  // The whole pipeline moves when the output register is free.
  assign adv        = !out_vld_r || out_tready;
  assign pop        = adv && q_nempty;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign st_nxt[ST_PRE] = prep(q_data);

  for (genvar g = 1; g < N_ST; g++) begin : g_stage
    assign st_nxt[g] = step(g, st_r[g-1]);
  end

  for (genvar g = 0; g < N_ST; g++) begin : g_reg
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  // Final sign and failure handling.
  assign lst = st_r[N_ST-1];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (lst.fail) begin
        out_data_nxt[16*j +: 16] = '0;
      end else if (lst.neg[j]) begin
        out_data_nxt[16*j +: 16] = 16'd0 - {1'b0, lst.quo[j]};
      end else begin
        out_data_nxt[16*j +: 16] = {1'b0, lst.quo[j]};
      end
    end
    out_user_nxt = lst.fail ? lst.code : OUT_OK;
  end

  always_comb begin
    vld_nxt     = vld_r;
    out_vld_nxt = out_vld_r;
    if (adv) begin
      vld_nxt     = {vld_r[N_ST-2:0], q_nempty};
      out_vld_nxt = vld_r[N_ST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule

// ----- rtl/core/refract_direction.sv -----
// ----------------------------------------------------------------------------
// refract_direction: Snell-law refraction of a direction vector
// Top level: front stage, item queue and refraction pipeline.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless the output stalls and returns
// one result per item, in order, via the front stage, the queue, 94 back
// stages and the output register. Most stages form the bit-per-stage index
// ratio divider, the two square roots and the normalizing dividers. A zero
// index or a zero-length vector gives outcome 3, a bad dot product outcome 2
// and total internal reflection outcome 1, each with a zero vector.
module refract_direction
  import refr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // normal_x, normal_y, normal_z, eye_x, eye_y, eye_z, index_incident,
  // index_transmit, 16 bits each from the lowest bit up
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // dir_x, dir_y, dir_z, 16 bits each from the lowest bit up
  output logic [47:0]  out_tdata,
  // outcome
  output logic [1:0]   out_tuser
);

  logic push, q_full, pop, q_nempty;
  fr_t  push_data, q_data;

  refr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  refr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_data),
    .full    (q_full),
    .rd_en   (pop),
    .rd_data (q_data),
    .nempty  (q_nempty)
  );

  refr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nempty   (q_nempty),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- tb/refract_direction_tb.sv -----
// ----------------------------------------------------------------------------
// refract_direction_tb: self-checking bench for the refraction pipeline
// Drives normal, eye and index items through the stream input, predicts each
// refracted direction and outcome in fixed point, and checks results in order.
// ----------------------------------------------------------------------------
module refract_direction_tb;
  import refr_pkg::*;

  typedef struct packed {
    logic [15:0] nt;
    logic [15:0] ni;
    logic [15:0] ez;
    logic [15:0] ey;
    logic [15:0] ex;
    logic [15:0] nz;
    logic [15:0] ny;
    logic [15:0] nx;
  } hit_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [15:0] dz;
    logic [15:0] dy;
    logic [15:0] dx;
  } dir_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic [1:0]   out_tuser;

  dir_t   pending_dirs[$];
  int     fail_count;
  int     hits_sent;
  int     dirs_seen;
  int     code_seen[4];
  bit     quiet_mode;
  bit     hold_sink;

  refract_direction dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Floor integer square root.
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Floor division by 2^14 of a signed value.
  function automatic longint floor14(input longint v);
    return v >>> 14;
  endfunction

  // Expected direction and outcome for one surface hit.
  function automatic dir_t refract(input hit_t h);
    dir_t   r;
    longint n[3], e[3], t[3];
    longint ni, nt, eta, dot, en, s, eta2, k, sq;
    logic [63:0] mag[3];
    logic [63:0] mx, sum, len, q;
    n[0] = longint'($signed(h.nx));
    n[1] = longint'($signed(h.ny));
    n[2] = longint'($signed(h.nz));
    e[0] = longint'($signed(h.ex));
    e[1] = longint'($signed(h.ey));
    e[2] = longint'($signed(h.ez));
    ni = longint'(h.ni);
    nt = longint'(h.nt);
    r = '0;
    if (ni == 0 || nt == 0) begin
      r.code = OUT_ZERO;
      return r;
    end
    eta = (ni <<< 14) / nt;
    if (eta > longint'(ETA_MAX)) eta = longint'(ETA_MAX);
    dot = n[0] * e[0] + n[1] * e[1] + n[2] * e[2];
    en = floor14(dot);
    s = (longint'(1) <<< 28) - en * en;
    if (s < 0) begin
      r.code = OUT_BAD_DOT;
      return r;
    end
    eta2 = (eta * eta) >>> 14;
    k = (longint'(1) <<< 42) - eta2 * s;
    if (k < 0) begin
      r.code = OUT_TIR;
      return r;
    end
    sq = longint'(int_sqrt(64'(k >>> 14)));
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      t[i] = (n[i] * en - (e[i] <<< 14)) * eta - ((n[i] * sq) <<< 14);
      mag[i] = (t[i] < 0) ? 64'(-t[i]) : 64'(t[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      r.code = OUT_ZERO;
      return r;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = int_sqrt(sum);
    q = (mag[0] << 14) / len;
    r.dx = (t[0] < 0) ? 16'(-q) : 16'(q);
    q = (mag[1] << 14) / len;
    r.dy = (t[1] < 0) ? 16'(-q) : 16'(q);
    q = (mag[2] << 14) / len;
    r.dz = (t[2] < 0) ? 16'(-q) : 16'(q);
    r.code = OUT_OK;
    return r;
  endfunction

  // Offer one item, with an optional random gap first, and wait for acceptance.
  task automatic send_hit(input hit_t h);
    int gap;
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= h;
    pending_dirs.push_back(refract(h));
    hits_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic pause_sender();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Roughly unit vector in Q2.14 along a random direction.
  function automatic void unit_vec(output logic [15:0] x, output logic [15:0] y,
                                   output logic [15:0] z);
    real a, b, c, m;
    a = real'($urandom_range(0, 2000)) - 1000.0;
    b = real'($urandom_range(0, 2000)) - 1000.0;
    c = real'($urandom_range(0, 2000)) - 1000.0;
    m = $sqrt(a * a + b * b + c * c);
    if (m < 1.0) begin
      a = 1000.0;
      m = 1000.0;
    end
    x = 16'($rtoi(a / m * 16383.0) + $signed($urandom_range(0, 4)) - 2);
    y = 16'($rtoi(b / m * 16383.0) + $signed($urandom_range(0, 4)) - 2);
    z = 16'($rtoi(c / m * 16383.0) + $signed($urandom_range(0, 4)) - 2);
  endfunction

  function automatic hit_t rand_hit();
    hit_t h;
    h = hit_t'({$urandom, $urandom, $urandom, $urandom});
    return h;
  endfunction

  // Plausible hit: unit normal, unit eye, indices near common media.
  function automatic hit_t real_hit();
    hit_t h;
    unit_vec(h.nx, h.ny, h.nz);
    unit_vec(h.ex, h.ey, h.ez);
    if ($urandom_range(0, 1)) begin
      h.ex = -h.ex;
      h.ey = -h.ey;
      h.ez = -h.ez;
    end
    h.ni = 16'($urandom_range(16384, 40000));
    h.nt = 16'($urandom_range(16384, 40000));
    return h;
  endfunction

  // Extremes of the fields and each special outcome.
  task automatic test_directed();
    hit_t h;
    h = '0;
    h.nz = 16'h4000;
    h.ez = 16'h4000;
    h.ni = 16'h4000;
    h.nt = 16'h4000;
    send_hit(h);                    // straight through, along the normal
    h.ni = 16'h0000;
    send_hit(h);                    // zero incident index
    h.ni = 16'h4000;
    h.nt = 16'h0000;
    send_hit(h);                    // zero transmit index
    h.nt = 16'h4000;
    h.ez = 16'h7FFF;
    h.nz = 16'h7FFF;
    send_hit(h);                    // dot product above one
    h = '0;
    h.nz = 16'h4000;
    h.ex = 16'h4000;
    h.ni = 16'h6000;
    h.nt = 16'h4000;
    send_hit(h);                    // grazing from a denser medium
    h.ni = 16'hFFFF;
    h.nt = 16'h0001;
    send_hit(h);                    // ratio saturates
    h.ex = 16'h0000;
    h.ez = 16'h4000;
    send_hit(h);                    // saturated ratio along the normal
    h = '0;
    h.ni = 16'h4000;
    h.nt = 16'h4000;
    send_hit(h);                    // zero-length result
    h = '0;
    h.ex = 16'h4000;
    h.ni = 16'h4000;
    h.nt = 16'h4000;
    send_hit(h);                    // zero normal, eye only
    h = {8{16'h8000}};
    send_hit(h);
    h = {8{16'h7FFF}};
    send_hit(h);
    h = {8{16'hFFFF}};
    send_hit(h);
    h = {{2{16'h0001}}, {6{16'h8000}}};
    send_hit(h);
    h = {{2{16'hFFFF}}, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
    send_hit(h);
    for (int i = 0; i < 6; i++) send_hit(real_hit());
    pause_sender();
  endtask

  // Mostly physical hits with random content, some raw noise.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) send_hit(real_hit());
      else send_hit(rand_hit());
    end
    pause_sender();
  endtask

  // Output side holds off long enough that the pipeline backs up to the input.
  task automatic test_backpressure();
    hold_sink = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 200; i++) send_hit(real_hit());
    join
    pause_sender();
  endtask

  // Back-to-back items with the receiver always ready.
  task automatic test_full_rate();
    quiet_mode = 1'b1;
    for (int i = 0; i < 200; i++) begin
      if ($urandom_range(0, 9) < 8) send_hit(real_hit());
      else send_hit(rand_hit());
    end
    pause_sender();
  endtask

  // Receiver: random stall bursts unless quiet, always stalled while held.
  initial begin
    int burst;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_sink) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    dir_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_dirs.size() == 0) begin
        $error("result with no item pending: dir %h outcome %0d", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_dirs.pop_front();
        dirs_seen++;
        code_seen[out_tuser]++;
        if (out_tdata[15:0] !== want.dx) begin
          $error("dir_x expected %h actual %h", want.dx, out_tdata[15:0]);
          fail_count++;
        end
        if (out_tdata[31:16] !== want.dy) begin
          $error("dir_y expected %h actual %h", want.dy, out_tdata[31:16]);
          fail_count++;
        end
        if (out_tdata[47:32] !== want.dz) begin
          $error("dir_z expected %h actual %h", want.dz, out_tdata[47:32]);
          fail_count++;
        end
        if (out_tuser !== want.code) begin
          $error("outcome expected %0d actual %0d", want.code, out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    fail_count = 0;
    hits_sent  = 0;
    dirs_seen  = 0;
    quiet_mode = 1'b0;
    hold_sink  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_backpressure();
    test_random(250);
    test_full_rate();
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Sent %0d hits, checked %0d directions.", hits_sent, dirs_seen);
    $display("Outcomes ok %0d, reflection %0d, bad dot %0d, zero %0d.",
             code_seen[0], code_seen[1], code_seen[2], code_seen[3]);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
